/* src/rte_pkg.sv */
// ----------------------------------------------------------------------------
// rte_pkg
// Types and constants shared by the ribbon trail extruder modules.
// ----------------------------------------------------------------------------
package rte_pkg;

  localparam int unsigned UNIT_Q14    = 16384;
  localparam int unsigned WIDTH_RESET = 240;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned QP_W        = 1;
  localparam int unsigned VEC_W       = 18;
  localparam int unsigned ROOT_W      = 26;
  localparam int unsigned QUO_W       = 16;

  typedef enum logic [1:0] {
    KIND_PRIME,
    KIND_FIRST,
    KIND_SMOOTH
  } kind_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    kind_t              kind;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic               done;
    logic               degen;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } norm_res_t;

endpackage

/* src/rte_queue.sv */
// ----------------------------------------------------------------------------
// rte_queue
// Short FIFO of classified points between front and back.
// ----------------------------------------------------------------------------
module rte_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rte_pkg::item_t  push_item,
  input  logic            pop,
  output rte_pkg::item_t  head,
  output rte_pkg::q_stat_t stat
);
  import rte_pkg::*;

  item_t           mem [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QP_W:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QP_W+1)'(Q_DEPTH));

endmodule

/* src/rte_front.sv */
// ----------------------------------------------------------------------------
// rte_front
// Accepts points and tags each as priming, first segment or smoothed segment.
// ----------------------------------------------------------------------------
module rte_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic [7:0]         color_red,
  input  logic [7:0]         color_green,
  input  logic [7:0]         color_blue,
  input  rte_pkg::q_stat_t   q_stat,
  output logic               push,
  output rte_pkg::item_t     push_item
);
  import rte_pkg::*;

  logic [1:0] points_seen;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.x = point_x;
    push_item.y = point_y;
    push_item.r = color_red;
    push_item.g = color_green;
    push_item.b = color_blue;
    case (points_seen)
      2'd0:    push_item.kind = KIND_PRIME;
      2'd1:    push_item.kind = KIND_FIRST;
      default: push_item.kind = KIND_SMOOTH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= '0;
    end else if (push && points_seen != 2'd2) begin
      points_seen <= points_seen + 1'b1;
    end
  end

endmodule

/* src/rte_norm.sv */
// ----------------------------------------------------------------------------
// rte_norm
// Iterative vector normalizer: squares, bit-pair square root, then one
// restoring division per component, one bit per cycle. Result is Q1.14.
// ----------------------------------------------------------------------------
module rte_norm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [rte_pkg::VEC_W-1:0] vx,
  input  logic signed [rte_pkg::VEC_W-1:0] vy,
  output rte_pkg::norm_res_t             res
);
  import rte_pkg::*;

  typedef enum logic [2:0] {
    N_IDLE, N_SQX, N_SQY, N_CHK, N_SQRT, N_DSET, N_DIV
  } nstate_t;

  nstate_t                  state;
  logic signed [VEC_W-1:0]  ax;
  logic signed [VEC_W-1:0]  ay;
  logic [2*VEC_W-1:0]       m2;
  logic [2*VEC_W+15:0]      rad;
  logic [ROOT_W-1:0]        root;
  logic [ROOT_W+3:0]        srem;
  logic [4:0]               cnt;
  logic                     sel;
  logic                     neg;
  logic [ROOT_W:0]          drem;
  logic [QUO_W-1:0]         dlow;
  logic [QUO_W-1:0]         quo;

  logic signed [2*VEC_W-1:0] sqx;
  logic signed [2*VEC_W-1:0] sqy;
  logic [ROOT_W+3:0]         srem_sh;
  logic [ROOT_W+3:0]         trial;
  logic signed [VEC_W-1:0]   comp;
  logic [VEC_W-1:0]          mag;
  logic [39:0]               dvd;
  logic [ROOT_W:0]           dsh;
  logic [QUO_W-1:0]          quo_next;
  logic [QUO_W-1:0]          qclamp;
  logic signed [15:0]        qsigned;
  logic                      done_next;

  assign sqx     = ax * ax;
  assign sqy     = ay * ay;
  assign srem_sh = {srem[ROOT_W+1:0], rad[2*VEC_W+15 -: 2]};
  assign trial   = (ROOT_W+4)'({root, 2'b01});
  assign comp    = sel ? ay : ax;
  assign mag     = comp[VEC_W-1] ? VEC_W'(-comp) : VEC_W'(comp);
  // |v| * 2^22 plus half the length, so the quotient rounds half away from zero
  assign dvd     = {mag, 22'b0} + 40'(root >> 1);
  assign dsh     = {drem[ROOT_W-1:0], dlow[QUO_W-1]};
  assign quo_next = {quo[QUO_W-2:0], (dsh >= {1'b0, root})};
  assign qclamp  = (quo_next > QUO_W'(UNIT_Q14)) ? QUO_W'(UNIT_Q14) : quo_next;
  assign qsigned = neg ? -$signed(qclamp) : $signed(qclamp);
  assign done_next = ((state == N_CHK) && (m2 == '0)) ||
                     ((state == N_DIV) && (cnt == 5'(QUO_W-1)) && sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= N_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= done_next;
      case (state)
        N_IDLE: begin
          if (start) begin
            ax    <= vx;
            ay    <= vy;
            state <= N_SQX;
          end
        end
        N_SQX: begin
          m2    <= unsigned'(sqx);
          state <= N_SQY;
        end
        N_SQY: begin
          m2    <= m2 + unsigned'(sqy);
          state <= N_CHK;
        end
        N_CHK: begin
          if (m2 == '0) begin
            res.nx    <= '0;
            res.ny    <= '0;
            res.degen <= 1'b1;
            state     <= N_IDLE;
          end else begin
            rad   <= {m2, 16'b0};
            root  <= '0;
            srem  <= '0;
            cnt   <= '0;
            state <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (srem_sh >= trial) begin
            srem <= srem_sh - trial;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            srem <= srem_sh;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          rad <= rad << 2;
          cnt <= cnt + 1'b1;
          if (cnt == 5'(ROOT_W-1)) begin
            sel   <= 1'b0;
            state <= N_DSET;
          end
        end
        N_DSET: begin
          // quotient fits 16 bits, so the top of the dividend is below the length
          drem  <= (ROOT_W+1)'(dvd[39:QUO_W]);
          dlow  <= dvd[QUO_W-1:0];
          neg   <= comp[VEC_W-1];
          quo   <= '0;
          cnt   <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          drem <= (dsh >= {1'b0, root}) ? dsh - {1'b0, root} : dsh;
          dlow <= dlow << 1;
          quo  <= quo_next;
          cnt  <= cnt + 1'b1;
          if (cnt == 5'(QUO_W-1)) begin
            if (!sel) begin
              res.nx <= qsigned;
              sel    <= 1'b1;
              state  <= N_DSET;
            end else begin
              res.ny    <= qsigned;
              res.degen <= 1'b0;
              state     <= N_IDLE;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

/* src/rte_back.sv */
// ----------------------------------------------------------------------------
// rte_back
// Takes classified points from the queue, computes normals through the
// shared normalizer and emits the fix-up and quad vertices.
// ----------------------------------------------------------------------------
module rte_back #(
  parameter int unsigned QUAD_SLOTS = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [11:0]                      trail_width,
  input  rte_pkg::item_t                   head,
  input  rte_pkg::q_stat_t                 q_stat,
  output logic                             pop,
  output logic                             norm_start,
  output logic signed [rte_pkg::VEC_W-1:0] norm_vx,
  output logic signed [rte_pkg::VEC_W-1:0] norm_vy,
  input  rte_pkg::norm_res_t               norm_res,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [8:0]                       vertex_slot,
  output logic signed [15:0]               vertex_x,
  output logic signed [15:0]               vertex_y,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic                             is_fixup,
  output logic                             degenerate,
  output logic                             last
);
  import rte_pkg::*;

  localparam int unsigned QW = (QUAD_SLOTS > 1) ? $clog2(QUAD_SLOTS) : 1;
  localparam int unsigned SW = (QW + 2 > 9) ? QW + 2 : 9;

  // emission order within one point
  localparam logic [2:0] V_FIX1 = 3'd0;
  localparam logic [2:0] V_FIX2 = 3'd1;
  localparam logic [2:0] V_C0   = 3'd2;
  localparam logic [2:0] V_C1   = 3'd3;
  localparam logic [2:0] V_C2   = 3'd4;
  localparam logic [2:0] V_C3   = 3'd5;

  typedef enum logic [1:0] {B_IDLE, B_WAIT_B, B_WAIT_A, B_EMIT} bstate_t;

  bstate_t            state;
  item_t              cur;
  logic signed [15:0] prev_x;
  logic signed [15:0] prev_y;
  logic signed [15:0] prev_nx;
  logic signed [15:0] prev_ny;
  logic signed [15:0] nbx;
  logic signed [15:0] nby;
  logic signed [15:0] nax;
  logic signed [15:0] nay;
  logic               degb;
  logic               dega;
  logic [QW-1:0]      quad;
  logic [2:0]         vidx;

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [QW-1:0]      prev_quad;
  logic [QW-1:0]      quad_next;
  logic               use_a;
  logic               minus;
  logic [1:0]         corner;
  logic [QW-1:0]      sel_quad;
  logic [SW-1:0]      slot_wide;
  logic signed [15:0] sel_px;
  logic signed [15:0] sel_py;
  logic signed [15:0] sel_nx;
  logic signed [15:0] sel_ny;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               emit;
  logic               norm_start_next;

  function automatic logic signed [15:0] place(logic signed [15:0] p,
                                               logic signed [15:0] n,
                                               logic [11:0] w, logic sub);
    logic signed [28:0] prod;
    logic [28:0]        pmag;
    logic [28:0]        rnd;
    logic signed [17:0] off;
    logic signed [17:0] sum;
    prod = n * $signed({1'b0, w});
    pmag = prod[28] ? 29'(-prod) : 29'(prod);
    rnd  = pmag + 29'd16384;
    off  = $signed({6'b0, rnd[26:15]});
    if (prod[28] != sub) sum = 18'(p) - off;
    else                 sum = 18'(p) + off;
    if (sum > 18'sd32767)       place = 16'sh7FFF;
    else if (sum < -18'sd32768) place = 16'sh8000;
    else                        place = sum[15:0];
  endfunction

  assign dx        = 17'(cur.x) - 17'(prev_x);
  assign dy        = 17'(cur.y) - 17'(prev_y);
  assign prev_quad = (quad == '0) ? QW'(QUAD_SLOTS - 1) : quad - 1'b1;
  assign quad_next = (quad == QW'(QUAD_SLOTS - 1)) ? '0 : quad + 1'b1;

  always_comb begin
    if (state == B_WAIT_B) begin
      norm_vx = -VEC_W'(dy);
      norm_vy = VEC_W'(dx);
    end else begin
      norm_vx = VEC_W'(nbx) + VEC_W'(prev_nx);
      norm_vy = VEC_W'(nby) + VEC_W'(prev_ny);
    end
  end

  always_comb begin
    use_a  = 1'b1;
    minus  = 1'b0;
    corner = 2'd0;
    case (vidx)
      V_FIX1: corner = 2'd1;
      V_FIX2: begin corner = 2'd2; minus = 1'b1; end
      V_C0:   corner = 2'd0;
      V_C1:   begin corner = 2'd1; use_a = 1'b0; end
      V_C2:   begin corner = 2'd2; use_a = 1'b0; minus = 1'b1; end
      V_C3:   begin corner = 2'd3; minus = 1'b1; end
      default: corner = 2'd0;
    endcase
    sel_quad  = (vidx == V_FIX1 || vidx == V_FIX2) ? prev_quad : quad;
    slot_wide = SW'({sel_quad, corner});
    sel_px    = use_a ? prev_x : cur.x;
    sel_py    = use_a ? prev_y : cur.y;
    sel_nx    = use_a ? nax : nbx;
    sel_ny    = use_a ? nay : nby;
  end

  assign pos_x = place(sel_px, sel_nx, trail_width, minus);
  assign pos_y = place(sel_py, sel_ny, trail_width, minus);
  assign pop   = (state == B_IDLE) && !q_stat.empty;
  assign emit  = (state == B_EMIT) && (!out_valid || out_ready);
  assign norm_start_next =
    ((state == B_IDLE) && !q_stat.empty && (head.kind != KIND_PRIME)) ||
    ((state == B_WAIT_B) && norm_res.done && (cur.kind == KIND_SMOOTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      prev_x     <= '0;
      prev_y     <= '0;
      prev_nx    <= '0;
      prev_ny    <= '0;
      quad       <= '0;
      norm_start <= 1'b0;
      out_valid  <= 1'b0;
      vidx       <= '0;
    end else begin
      norm_start <= norm_start_next;
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!q_stat.empty) begin
            cur <= head;
            if (head.kind == KIND_PRIME) begin
              prev_x <= head.x;
              prev_y <= head.y;
            end else begin
              state <= B_WAIT_B;
            end
          end
        end
        B_WAIT_B: begin
          if (norm_res.done) begin
            nbx  <= norm_res.nx;
            nby  <= norm_res.ny;
            degb <= norm_res.degen;
            nax  <= norm_res.nx;
            nay  <= norm_res.ny;
            dega <= norm_res.degen;
            if (cur.kind == KIND_SMOOTH) begin
              vidx  <= V_FIX1;
              state <= B_WAIT_A;
            end else begin
              vidx  <= V_C0;
              state <= B_EMIT;
            end
          end
        end
        B_WAIT_A: begin
          if (norm_res.done) begin
            nax   <= norm_res.nx;
            nay   <= norm_res.ny;
            dega  <= norm_res.degen;
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (emit) begin
            vertex_slot <= slot_wide[8:0];
            vertex_x    <= pos_x;
            vertex_y    <= pos_y;
            out_red     <= cur.r;
            out_green   <= cur.g;
            out_blue    <= cur.b;
            is_fixup    <= (vidx == V_FIX1 || vidx == V_FIX2);
            degenerate  <= use_a ? dega : degb;
            last        <= (vidx == V_C3);
            if (vidx == V_C3) begin
              prev_x  <= cur.x;
              prev_y  <= cur.y;
              prev_nx <= nbx;
              prev_ny <= nby;
              quad    <= quad_next;
              state   <= B_IDLE;
            end else begin
              vidx <= vidx + 1'b1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* src/ribbon_trail_extruder_unit.sv */
// ----------------------------------------------------------------------------
// ribbon_trail_extruder_unit
// Turns a stream of trail points into ribbon quad vertices.
// ----------------------------------------------------------------------------
// The first point after reset only primes the block and gives no beat. The
// second point gives four vertex beats and every later point six (two fix-ups
// of the previous quad, then four corners). Throughput is set by the single
// shared normalizer, which resolves one root or quotient bit per cycle, and by
// stalls on the output side. A two-entry queue lets points be taken while
// earlier ones are in work.
module ribbon_trail_extruder_unit #(
  parameter int unsigned QUAD_SLOTS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [11:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic [7:0]         color_red,
  input  logic [7:0]         color_green,
  input  logic [7:0]         color_blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [8:0]         vertex_slot,
  output logic signed [15:0] vertex_x,
  output logic signed [15:0] vertex_y,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               is_fixup,
  output logic               degenerate,
  output logic               last
);
  import rte_pkg::*;

  logic                     trail_width_en;
  logic [11:0]              trail_width;
  logic                     push;
  item_t                    push_item;
  logic                     pop;
  item_t                    head;
  q_stat_t                  q_stat;
  logic                     norm_start;
  logic signed [VEC_W-1:0]  norm_vx;
  logic signed [VEC_W-1:0]  norm_vy;
  norm_res_t                norm_res;

  assign trail_width_en = cfg_wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      trail_width <= 12'(WIDTH_RESET);
    end else if (trail_width_en) begin
      trail_width <= cfg_wr_data;
    end
  end

  rte_front u_front (
    .clk, .rst, .in_valid, .in_ready, .point_x, .point_y,
    .color_red, .color_green, .color_blue,
    .q_stat, .push, .push_item
  );

  rte_queue u_queue (
    .clk, .rst, .push, .push_item, .pop, .head, .stat(q_stat)
  );

  rte_norm u_norm (
    .clk, .rst, .start(norm_start), .vx(norm_vx), .vy(norm_vy), .res(norm_res)
  );

  rte_back #(.QUAD_SLOTS(QUAD_SLOTS)) u_back (
    .clk, .rst, .trail_width, .head, .q_stat, .pop,
    .norm_start, .norm_vx, .norm_vy, .norm_res,
    .out_valid, .out_ready, .vertex_slot, .vertex_x, .vertex_y,
    .out_red, .out_green, .out_blue, .is_fixup, .degenerate, .last
  );

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    norm_res.done |=> !norm_res.done)
    else $error("normalizer done held longer than one cycle");

  a_fixup_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_fixup && last))
    else $error("fix-up vertex flagged as last");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    norm_start |-> !norm_res.done)
    else $error("normalizer restarted while finishing");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Ribbon trail extruder testbench. Random trail points go in with random
// gaps, and vertex beats come out under random backpressure. A scoreboard
// predicts every vertex beat from the accepted points and checks each output
// beat against it. Width settings change only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import rte_pkg::*;

  localparam int unsigned QUADS = 128;

  typedef struct packed {
    logic [8:0]         slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic               fix;
    logic               deg;
    logic               lst;
  } vertex_t;

  class vertex_scoreboard;
    vertex_t     want_q[$];
    int unsigned width_q84;
    int          last_x, last_y, last_nx, last_ny;
    int unsigned seen;
    int unsigned quad_no;
    int unsigned errors;

    function new();
      width_q84 = WIDTH_RESET;
      last_x = 0; last_y = 0; last_nx = 0; last_ny = 0;
      seen = 0; quad_no = 0; errors = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // rounding division, ties away from zero
    function longint round_div(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function int clamp_unit(longint v);
      if (v > longint'(UNIT_Q14)) return int'(UNIT_Q14);
      if (v < -longint'(UNIT_Q14)) return -int'(UNIT_Q14);
      return int'(v);
    endfunction

    // returns 1 when the vector is zero
    function bit unit_normal(longint vx, longint vy, output int ox, output int oy);
      longint unsigned m2, len;
      m2 = longint'(vx * vx) + longint'(vy * vy);
      if (m2 == 0) begin
        ox = 0; oy = 0;
        return 1'b1;
      end
      len = int_sqrt(m2 << 16);
      ox = clamp_unit(round_div(vx * 4194304, longint'(len)));
      oy = clamp_unit(round_div(vy * 4194304, longint'(len)));
      return 1'b0;
    endfunction

    function logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function void push_vertex(int unsigned slot, int px, int py, int nx, int ny,
                              bit neg, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              bit fix, bit deg, bit lst);
      vertex_t v;
      longint ox, oy;
      ox = round_div(longint'(nx) * longint'(width_q84), 32768);
      oy = round_div(longint'(ny) * longint'(width_q84), 32768);
      v.slot = slot[8:0];
      v.x = neg ? sat16(px - ox) : sat16(px + ox);
      v.y = neg ? sat16(py - oy) : sat16(py + oy);
      v.r = r; v.g = g; v.b = b;
      v.fix = fix; v.deg = deg; v.lst = lst;
      want_q.insert(want_q.size(), v);
    endfunction

    function void note_point(logic signed [15:0] px, logic signed [15:0] py,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int bx, by, nbx, nby, nax, nay;
      bit degb, dega;
      int unsigned pq, base;
      bx = px; by = py;
      if (seen == 0) begin
        last_x = bx; last_y = by;
        seen = 1;
        return;
      end
      degb = unit_normal(-(longint'(by) - last_y), longint'(bx) - last_x, nbx, nby);
      nax = nbx; nay = nby; dega = degb;
      if (seen >= 2) begin
        pq = (quad_no + QUADS - 1) % QUADS;
        dega = unit_normal(longint'(nbx) + last_nx, longint'(nby) + last_ny, nax, nay);
        push_vertex(pq * 4 + 1, last_x, last_y, nax, nay, 0, r, g, b, 1, dega, 0);
        push_vertex(pq * 4 + 2, last_x, last_y, nax, nay, 1, r, g, b, 1, dega, 0);
      end
      base = quad_no * 4;
      push_vertex(base + 0, last_x, last_y, nax, nay, 0, r, g, b, 0, dega, 0);
      push_vertex(base + 1, bx, by, nbx, nby, 0, r, g, b, 0, degb, 0);
      push_vertex(base + 2, bx, by, nbx, nby, 1, r, g, b, 0, degb, 0);
      push_vertex(base + 3, last_x, last_y, nax, nay, 1, r, g, b, 0, dega, 1);
      last_nx = nbx; last_ny = nby;
      last_x = bx; last_y = by;
      quad_no = (quad_no + 1) % QUADS;
      seen = 2;
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t w;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex beat %p", $time, got);
        return;
      end
      w = want_q.pop_front();
      if (got.slot !== w.slot || got.x !== w.x || got.y !== w.y || got.r !== w.r ||
          got.g !== w.g || got.b !== w.b || got.fix !== w.fix || got.deg !== w.deg ||
          got.lst !== w.lst) begin
        errors++;
        $display("%0t: vertex mismatch expected %p actual %p", $time, w, got);
      end
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [11:0]        cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] point_x = '0;
  logic signed [15:0] point_y = '0;
  logic [7:0]         color_red = '0;
  logic [7:0]         color_green = '0;
  logic [7:0]         color_blue = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [8:0]         vertex_slot;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic [7:0]         out_red, out_green, out_blue;
  logic               is_fixup, degenerate, last;

  vertex_scoreboard sb = new();
  int cur_x, cur_y, back_x, back_y;

  ribbon_trail_extruder_unit #(.QUAD_SLOTS(QUADS)) u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .point_x(point_x), .point_y(point_y),
    .color_red(color_red), .color_green(color_green), .color_blue(color_blue),
    .out_valid(out_valid), .out_ready(out_ready), .vertex_slot(vertex_slot),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue), .is_fixup(is_fixup),
    .degenerate(degenerate), .last(last)
  );

  always #1 clk = ~clk;

  function int unsigned pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // output backpressure; stretches of always-ready mixed in
  initial begin
    int unsigned n;
    @(negedge rst);
    forever begin
      n = pick_gap();
      if (n == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_vertex({vertex_slot, vertex_x, vertex_y, out_red, out_green, out_blue,
                       is_fixup, degenerate, last});
  end

  task automatic send_point(int px, int py, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, bit gaps);
    int unsigned n;
    n = gaps ? pick_gap() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    point_x <= px[15:0];
    point_y <= py[15:0];
    color_red <= r;
    color_green <= g;
    color_blue <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_point(point_x, point_y, color_red, color_green, color_blue);
    back_x = cur_x; back_y = cur_y;
    cur_x = px; cur_y = py;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // a priming point may still sit in the block with no beat due
    repeat (300) @(posedge clk);
  endtask

  task automatic set_width(logic [11:0] w);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.width_q84 = w;
  endtask

  task automatic random_points(int unsigned count);
    int px, py;
    int unsigned sel;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        px = $urandom; py = $urandom;
        px = $signed(px[15:0]); py = $signed(py[15:0]);
      end else if (sel < 13) begin
        px = cur_x; py = cur_y;
      end else if (sel < 18) begin
        px = back_x; py = back_y;
      end else begin
        px = cur_x + int'($urandom_range(0, 400)) - 200;
        py = cur_y + int'($urandom_range(0, 400)) - 200;
        if (px > 32767) px = 32767;
        if (px < -32768) px = -32768;
        if (py > 32767) py = 32767;
        if (py < -32768) py = -32768;
      end
      send_point(px, py, $urandom, $urandom, $urandom, 1);
    end
  endtask

  initial begin
    cur_x = 0; cur_y = 0; back_x = 0; back_y = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full-range corners, zero-length segment, reversal
    send_point(-32768, -32768, 8'h00, 8'h00, 8'h00, 0);
    send_point(32767, 32767, 8'hff, 8'hff, 8'hff, 0);
    send_point(32767, 32767, 8'h00, 8'hff, 8'h00, 0);
    send_point(-32768, 32767, 8'hff, 8'h00, 8'hff, 0);
    send_point(100, 100, 8'h55, 8'haa, 8'h0f, 0);
    send_point(300, 100, 8'haa, 8'h55, 8'hf0, 0);
    send_point(100, 100, 8'h01, 8'h80, 8'h7f, 0);
    send_point(100, 100, 8'h12, 8'h34, 8'h56, 0);
    send_point(100, 400, 8'hfe, 8'h01, 8'h80, 0);
    send_point(32767, -32768, 8'h33, 8'hcc, 8'h99, 0);
    send_point(-32768, -32768, 8'h0f, 8'hf0, 8'h3c, 0);
    send_point(0, 0, 8'hc3, 8'h3c, 8'h5a, 0);

    set_width(12'd0);
    send_point(5, 5, 8'h10, 8'h20, 8'h30, 0);
    send_point(-5, 5, 8'h40, 8'h50, 8'h60, 0);
    set_width(12'hfff);
    send_point(32767, 0, 8'h70, 8'h80, 8'h90, 0);
    send_point(-32768, 0, 8'ha0, 8'hb0, 8'hc0, 0);
    send_point(-32768, 16, 8'hd0, 8'he0, 8'hf0, 0);

    set_width(12'd240);
    random_points(90);
    // hold the sender until every beat is out
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    random_points(40);
    set_width(12'hfff);
    random_points(60);
    set_width(12'd0);
    random_points(20);
    set_width($urandom_range(1, 4094));
    random_points(80);

    drain();
    if (sb.errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #6000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
